FILE: sv/frequency_bcd_codec_assert.svh
// Assertion macros shared by the frequency BCD codec checkers.
// No dependencies; the including file supplies clock and reset names.
`ifndef FREQUENCY_BCD_CODEC_ASSERT_SVH
`define FREQUENCY_BCD_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frequency_bcd_codec: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frequency_bcd_codec: next-cycle check failed");

`endif

FILE: sv/fcd_pkg.sv
// Package for the frequency BCD codec: payload structs, pipeline record,
// sizing constants and constant-weight helpers. No dependencies.
`default_nettype none

package fcd_pkg;

    localparam int HZ_W       = 40;
    localparam int BCD_W      = 40;
    localparam int HZ_OUT_W   = 38;
    localparam int CONST_W    = 44;   // holds 9 * 10^12
    localparam int BCD_BYTES  = 5;
    // Digits kept in the field, capped by the port width.
    localparam int NUM_DIGITS = (2 * BCD_BYTES < BCD_W / 4) ? 2 * BCD_BYTES : BCD_W / 4;
    // A 40-bit hertz value has decimal positions 0..12; stages strip 12 down to 1.
    localparam int NUM_STAGES = 12;

    typedef struct packed {
        logic              operation;
        logic [HZ_W-1:0]   freq_hz;
        logic [BCD_W-1:0]  bcd_in;
    } fcd_in_t;

    typedef struct packed {
        logic [BCD_W-1:0]    bcd_out;
        logic [HZ_OUT_W-1:0] hz_out;
    } fcd_out_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } fcd_op_t;

    // Record carried down the pipeline.
    typedef struct packed {
        fcd_op_t             op;
        logic [HZ_W-1:0]     rem;   // hertz remainder below the current position
        logic [BCD_W-1:0]    src;   // packed BCD being decoded
        logic [BCD_W-1:0]    bcd;   // encoded digits so far
        logic [HZ_OUT_W-1:0] acc;   // decoded hertz so far
    } fcd_pipe_t;

    function automatic logic [63:0] pow10(input int unsigned n);
        logic [63:0] r;
        r = 64'd1;
        for (int unsigned k = 0; k < n; k++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    // d * 10^p at the compare width.
    function automatic logic [CONST_W-1:0] digit_step(input int unsigned p,
                                                      input int unsigned d);
        logic [63:0] r;
        r = pow10(p) * 64'(d);
        return r[CONST_W-1:0];
    endfunction

    // 10^(i+1) modulo 2^HZ_OUT_W: nibble weight with the final *10 folded in.
    function automatic logic [HZ_OUT_W-1:0] dec_weight(input int unsigned i);
        logic [63:0] r;
        r = pow10(i + 1);
        return r[HZ_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/frequency_bcd_codec.sv
// One result per input; throughput is one transfer per cycle unless m_ready
//   stalls the output; each of the 12 stages holds one item and moves on
//   whenever the stage after it is empty or draining.
// Reset: aresetn synchronous, active low; clears every stage valid bit, so the
//   pipeline comes up empty. Payload registers are not reset.
// Depends on fcd_pkg and fcd_stage.
`default_nettype none

module frequency_bcd_codec (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire fcd_pkg::fcd_in_t s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output fcd_pkg::fcd_out_t    m_data
);

    // Stage k handles hertz digit position 12-k for encode (positions above
    // the field are stripped but not stored, the units digit is left in the
    // remainder; position p lands in nibble p-1, which is the divide by ten)
    // and BCD nibble k for decode (weighted by 10^(k+1) so the final *10 is
    // already folded in, everything modulo 2^38 to match the output truncation).
    // Nibbles above nine are weighted as read.

    localparam int N = fcd_pkg::NUM_STAGES;

    logic               valid_chain [N+1];
    logic               ready_chain [N+1];
    fcd_pkg::fcd_pipe_t data_chain  [N+1];

    // Entry record: encode works on the remainder, decode on the source.
    assign data_chain[0] = '{op:  fcd_pkg::fcd_op_t'(s_data.operation),
                             rem: s_data.freq_hz,
                             src: s_data.bcd_in,
                             bcd: '0,
                             acc: '0};

    assign valid_chain[0] = s_valid;
    assign s_ready        = ready_chain[0];

    for (genvar k = 0; k < N; k++) begin : g_stage
        fcd_stage #(
            .STAGE(k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[k]),
            .in_ready  (ready_chain[k]),
            .in_data   (data_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_ready (ready_chain[k+1]),
            .out_data  (data_chain[k+1])
        );
    end

    // The last stage register is the output register; a waiting result only
    // holds the stages behind it that are full.
    assign ready_chain[N]  = m_ready;
    assign m_valid         = valid_chain[N];
    assign m_data.bcd_out  = data_chain[N].bcd;
    assign m_data.hz_out   = data_chain[N].acc;

endmodule

`default_nettype wire

FILE: sv/fcd_stage.sv
// One pipeline stage of the frequency BCD codec: strips one decimal digit
// (encode) and adds one weighted nibble (decode, stages below NUM_DIGITS only). Depends on fcd_pkg.
`default_nettype none

module fcd_stage #(
    parameter int STAGE = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fcd_pkg::fcd_pipe_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fcd_pkg::fcd_pipe_t     out_data
);

    localparam int POS      = fcd_pkg::NUM_STAGES - STAGE;
    localparam bit ENC_USED = (POS - 1) < fcd_pkg::NUM_DIGITS;
    localparam int ENC_NIB  = ENC_USED ? POS - 1 : 0;
    localparam bit DEC_USED = STAGE < fcd_pkg::NUM_DIGITS;
    localparam int DEC_NIB  = DEC_USED ? STAGE : 0;
    localparam logic [fcd_pkg::HZ_OUT_W-1:0] WEIGHT = fcd_pkg::dec_weight(DEC_NIB);

    logic                           valid_reg;
    logic                           valid_next;
    fcd_pkg::fcd_pipe_t             data_reg;
    fcd_pkg::fcd_pipe_t             data_next;
    logic [3:0]                     digit;
    logic [fcd_pkg::CONST_W-1:0]    rem_ext;
    logic [fcd_pkg::CONST_W-1:0]    sub;
    logic [fcd_pkg::CONST_W-1:0]    diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Digit by parallel compare against d*10^POS, then one subtract.
    always_comb begin
        rem_ext   = {{(fcd_pkg::CONST_W - fcd_pkg::HZ_W){1'b0}}, in_data.rem};
        digit     = '0;
        sub       = '0;
        for (int d = 1; d < 10; d++) begin
            if (rem_ext >= fcd_pkg::digit_step(POS, d)) begin
                digit = 4'(d);
                sub   = fcd_pkg::digit_step(POS, d);
            end
        end
        diff      = rem_ext - sub;
        data_next = in_data;
        data_next.rem = diff[fcd_pkg::HZ_W-1:0];
        if (ENC_USED && in_data.op == fcd_pkg::OP_ENCODE) begin
            data_next.bcd[ENC_NIB*4 +: 4] = digit;
        end
        if (DEC_USED && in_data.op == fcd_pkg::OP_DECODE) begin
            data_next.acc = in_data.acc
                          + fcd_pkg::HZ_OUT_W'(in_data.src[DEC_NIB*4 +: 4] * WEIGHT);
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fcd_checker.sv
// Port-level checker for frequency_bcd_codec, bound to the top level.
// Depends on fcd_pkg and frequency_bcd_codec_assert.svh.
`default_nettype none

`include "frequency_bcd_codec_assert.svh"

module fcd_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire fcd_pkg::fcd_out_t m_data
);

    localparam int CNT_W = $clog2(fcd_pkg::NUM_STAGES + 2);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             s_xfer;
    logic             m_xfer;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    // Items in flight: input transfers not yet matched by a result transfer.
    always_comb begin
        cnt_next = cnt_reg;
        if (s_xfer && !m_xfer) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!s_xfer && m_xfer) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `FCD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `FCD_ASSERT_IMPLY(a_fill_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(fcd_pkg::NUM_STAGES))
    `FCD_ASSERT_IMPLY(a_no_phantom, aclk, aresetn, m_valid, cnt_reg != '0)
    `FCD_ASSERT_IMPLY(a_one_side, aclk, aresetn, m_valid && m_data.bcd_out != '0, m_data.hz_out == '0)

endmodule

bind frequency_bcd_codec fcd_checker u_fcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for frequency_bcd_codec: directed rows, then random
// conversions under several idle/stall mixes, checked against a local predictor.
// Depends on fcd_pkg and the frequency_bcd_codec RTL.
`default_nettype none

module testbench;

    // Pipeline depth; the final wait for stray results derives from it.
    localparam int PIPE_LATENCY    = 12;
    localparam int NIBBLES         = fcd_pkg::BCD_W / 4;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int NUM_PHASES      = 4;
    localparam longint CYCLE_LIMIT = 300000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    fcd_pkg::fcd_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    fcd_pkg::fcd_out_t m_data;

    // Directed stimulus row; want_* only used when the answer is typed in.
    typedef struct {
        fcd_pkg::fcd_op_t              op;
        logic [fcd_pkg::HZ_W-1:0]      freq;
        logic [fcd_pkg::BCD_W-1:0]     bcd;
        bit                            known;
        logic [fcd_pkg::BCD_W-1:0]     want_bcd;
        logic [fcd_pkg::HZ_OUT_W-1:0]  want_hz;
    } dir_row_t;

    dir_row_t          directed_rows[$];
    fcd_pkg::fcd_out_t pending_conversions[$];
    fcd_pkg::fcd_out_t oldest_want;

    // Sideband for the transfer currently presented: a typed-in answer, if any.
    bit                frame_known;
    fcd_pkg::fcd_out_t frame_want;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned sent_count;
    int unsigned results_seen;
    longint      cycle_count;

    frequency_bcd_codec dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: encode packs (hz / 10) into ten BCD nibbles, dropping the
    // higher digits; decode weights every nibble as read (A..F included)
    // and scales the 10 Hz count back to hertz.
    // ------------------------------------------------------------------
    function automatic fcd_pkg::fcd_out_t convert_item(input fcd_pkg::fcd_in_t item);
        fcd_pkg::fcd_out_t r;
        logic [63:0]       units;
        r = '0;
        if (item.operation == fcd_pkg::OP_ENCODE) begin
            units = 64'(item.freq_hz) / 64'd10;
            for (int k = 0; k < NIBBLES; k++) begin
                r.bcd_out[4*k +: 4] = 4'(units % 64'd10);
                units = units / 64'd10;
            end
        end else begin
            units = 64'd0;
            for (int k = NIBBLES - 1; k >= 0; k--) begin
                units = units * 64'd10 + 64'(item.bcd_in[4*k +: 4]);
            end
            r.hz_out = fcd_pkg::HZ_OUT_W'(units * 64'd10);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void add_row(input fcd_pkg::fcd_op_t op,
                                    input logic [fcd_pkg::HZ_W-1:0] freq,
                                    input logic [fcd_pkg::BCD_W-1:0] bcd, input bit known,
                                    input logic [fcd_pkg::BCD_W-1:0] want_bcd,
                                    input logic [fcd_pkg::HZ_OUT_W-1:0] want_hz);
        dir_row_t row;
        row.op       = op;
        row.freq     = freq;
        row.bcd      = bcd;
        row.known    = known;
        row.want_bcd = want_bcd;
        row.want_hz  = want_hz;
        directed_rows.push_back(row);
    endfunction

    // Random request: mostly in-range frequencies and well-formed BCD, with
    // full-width values and out-of-range nibbles mixed in.
    function automatic fcd_pkg::fcd_in_t random_request();
        fcd_pkg::fcd_in_t item;
        logic [63:0]      wide;
        int unsigned      pick;
        item.operation = 1'($urandom_range(1));
        wide = {$urandom, $urandom};
        pick = $urandom_range(7);
        case (pick)
            0, 1, 2: item.freq_hz = fcd_pkg::HZ_W'(wide % 64'd1000000000000);
            3:       item.freq_hz = wide[fcd_pkg::HZ_W-1:0];
            4:       item.freq_hz = fcd_pkg::HZ_W'($urandom_range(100000));
            5: begin
                // Near a power of ten, where digit carries ripple.
                wide = 64'd1;
                repeat ($urandom_range(12)) wide = wide * 64'd10;
                item.freq_hz = fcd_pkg::HZ_W'(wide + 64'($urandom_range(20)) - 64'd10);
            end
            default: item.freq_hz = fcd_pkg::HZ_W'($urandom_range(450000000, 100000));
        endcase
        pick = $urandom_range(9);
        for (int k = 0; k < NIBBLES; k++) begin
            if (pick < 6)
                item.bcd_in[4*k +: 4] = 4'($urandom_range(9));
            else if (pick < 8)
                item.bcd_in[4*k +: 4] = 4'($urandom_range(15));
            else
                item.bcd_in[4*k +: 4] = ($urandom_range(1) != 0) ? 4'h9 : 4'hF;
        end
        return item;
    endfunction

    // Present one transfer; returns at the edge where it is accepted.
    // Idle cycles are inserted only before valid goes high.
    task automatic send_item(input fcd_pkg::fcd_in_t item, input bit known,
                             input fcd_pkg::fcd_out_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data      <= item;
        frame_known <= known;
        frame_want  <= want;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        sent_count++;
    endtask

    // Wait until every accepted transfer has produced its result.
    task automatic drain_results();
        while (results_seen < sent_count) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Monitor: queue the expectation on every input transfer, check every
    // result transfer against the oldest one, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (frame_known)
                    pending_conversions.push_back(frame_want);
                else
                    pending_conversions.push_back(convert_item(s_data));
            end
            if (m_valid && m_ready) begin
                if (pending_conversions.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    oldest_want = pending_conversions.pop_front();
                    if (m_data.bcd_out !== oldest_want.bcd_out)
                        report_mismatch($sformatf("bcd_out %h, want %h",
                                                  m_data.bcd_out, oldest_want.bcd_out));
                    if (m_data.hz_out !== oldest_want.hz_out)
                        report_mismatch($sformatf("hz_out %0d, want %0d",
                                                  m_data.hz_out, oldest_want.hz_out));
                end
                results_seen++;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle at the current stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop if the pipeline hangs or results go missing.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned       send_pct [NUM_PHASES];
        int unsigned       stall_pct[NUM_PHASES];
        fcd_pkg::fcd_in_t  item;
        fcd_pkg::fcd_out_t want;

        send_pct  = '{0, 86, 0, 25};
        stall_pct = '{0, 0, 86, 25};

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        frame_known    = 1'b0;
        frame_want     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        sent_count     = 0;
        results_seen   = 0;
        cycle_count    = 0;

        // Encode: zero, truncation below 10 Hz, smallest unit, field full,
        // carry out of the tenth digit dropped, largest 40-bit input.
        add_row(fcd_pkg::OP_ENCODE, 40'd0,             40'd0, 1, 40'h00_0000_0000, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd9,             40'd0, 1, 40'h00_0000_0000, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd10,            40'd0, 1, 40'h00_0000_0001, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd99999999999,   40'd0, 1, 40'h99_9999_9999, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd100000000000,  40'd0, 1, 40'h00_0000_0000, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd999999999999,  40'd0, 1, 40'h99_9999_9999, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd1099511627775, 40'd0, 1, 40'h99_5116_2777, 38'd0);
        add_row(fcd_pkg::OP_ENCODE, 40'd14074000,      40'hFF_FFFF_FFFF, 0, '0, '0);
        add_row(fcd_pkg::OP_ENCODE, 40'd145000000,     40'h12_3456_7890, 0, '0, '0);
        add_row(fcd_pkg::OP_ENCODE, 40'd1234567891,    40'd0, 0, '0, '0);
        // Decode: zero, lowest digit, all nines, all F, nibbles above nine.
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'h00_0000_0000, 1, 40'd0, 38'd0);
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'h00_0000_0001, 1, 40'd0, 38'd10);
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'h99_9999_9999, 1, 40'd0, 38'd99999999990);
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'hFF_FFFF_FFFF, 1, 40'd0, 38'd166666666650);
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'h00_0000_000F, 1, 40'd0, 38'd150);
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'h00_0000_00A0, 1, 40'd0, 38'd1000);
        add_row(fcd_pkg::OP_DECODE, 40'd0, 40'hF0_0000_0000, 1, 40'd0, 38'd150000000000);
        add_row(fcd_pkg::OP_DECODE, 40'hFF_FFFF_FFFF, 40'h00_0140_7400, 0, '0, '0);
        add_row(fcd_pkg::OP_DECODE, 40'd0,            40'h5A_C3B2_E1D0, 0, '0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, no idling.
        foreach (directed_rows[i]) begin
            item.operation = directed_rows[i].op;
            item.freq_hz   = directed_rows[i].freq;
            item.bcd_in    = directed_rows[i].bcd;
            want.bcd_out   = directed_rows[i].want_bcd;
            want.hz_out    = directed_rows[i].want_hz;
            send_item(item, directed_rows[i].known, want);
        end
        s_valid <= 1'b0;
        drain_results();

        // Random phases with different idle/stall mixes; drain between them.
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_request(), 1'b0, '0);
            end
            s_valid <= 1'b0;
            drain_results();
        end

        // Let any stray result show up before the verdict.
        recv_stall_pct = 0;
        repeat (2 * PIPE_LATENCY) @(posedge aclk);

        if (mismatch_count == 0 && pending_conversions.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/fcd_pkg.sv
sv/fcd_stage.sv
sv/frequency_bcd_codec.sv
sv/fcd_checker.sv
tb/sv/testbench.sv
